// ===== rtl/core/slcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_pkg
// Types and constants shared by the sync/length/checksum deframer.
// ----------------------------------------------------------------------------
package slcd_pkg;

	localparam int HEADER_BYTES = 6;
	localparam int LENGTH_BITS  = 16;

	localparam int BYTE_W   = 8;
	localparam int INDEX_W  = 12;
	localparam int MAXLEN_W = 13;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 2;

	typedef logic [LENGTH_BITS-1:0] len_t;

	// header, checksum, and nothing else: no payload
	localparam len_t EMPTY_FRAME_LEN = LENGTH_BITS'(HEADER_BYTES + 1);
	// largest length whose payload count still fits the index width
	localparam len_t PAYLOAD_LIMIT_LEN = LENGTH_BITS'(4102);
	localparam logic [BYTE_W-1:0] LEN_HI_AS_ZERO = 8'hFF;

	localparam logic [BYTE_W-1:0]   SYNC_FIRST_RST = 8'h5A;
	localparam logic [BYTE_W-1:0]   SYNC_SECOND_RST = 8'h59;
	localparam logic [MAXLEN_W-1:0] MAX_FRAME_LEN_RST = 13'd3096;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SYNC_FIRST  = 2'd0,
		CFG_SYNC_SECOND = 2'd1,
		CFG_MAX_LEN     = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_SYNC1    = 3'd0,
		PH_SYNC2    = 3'd1,
		PH_REMARK   = 3'd2,
		PH_LEN_HI   = 3'd3,
		PH_LEN_LO   = 3'd4,
		PH_TYPE     = 3'd5,
		PH_PAYLOAD  = 3'd6,
		PH_CHECKSUM = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_SUM_OK  = 2'd1,
		KIND_SUM_BAD = 2'd2
	} kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   sync_first;
		logic [BYTE_W-1:0]   sync_second;
		logic [MAXLEN_W-1:0] max_len;
	} cfg_t;

	typedef struct packed {
		phase_t              phase;
		len_t                frame_len;
		logic [BYTE_W-1:0]   sum;
		logic [BYTE_W-1:0]   remark;
		logic [BYTE_W-1:0]   ftype;
		logic [INDEX_W-1:0]  count;
	} parse_state_t;

	typedef struct packed {
		kind_t               kind;
		logic [BYTE_W-1:0]   payload_byte;
		logic [INDEX_W-1:0]  byte_index;
		logic                last_payload;
		logic [BYTE_W-1:0]   remark_id;
		logic [BYTE_W-1:0]   frame_type;
		logic [INDEX_W-1:0]  payload_length;
	} result_t;

endpackage

// ===== rtl/core/slcd_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_ifs
// Valid/ready channels for received bytes and deframer results.
// ----------------------------------------------------------------------------
interface slcd_in_if;
	logic                         valid;
	logic                         ready;
	logic [slcd_pkg::BYTE_W-1:0]  rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcd_out_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    out_kind;
	logic [slcd_pkg::BYTE_W-1:0]   payload_byte;
	logic [slcd_pkg::INDEX_W-1:0]  byte_index;
	logic                          last_payload;
	logic [slcd_pkg::BYTE_W-1:0]   remark_id;
	logic [slcd_pkg::BYTE_W-1:0]   frame_type;
	logic [slcd_pkg::INDEX_W-1:0]  payload_length;

	modport source (output valid, output out_kind, output payload_byte, output byte_index,
		output last_payload, output remark_id, output frame_type, output payload_length,
		input ready);
	modport sink (input valid, input out_kind, input payload_byte, input byte_index,
		input last_payload, input remark_id, input frame_type, input payload_length,
		output ready);
endinterface

// ===== rtl/core/slcd_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_step
// Next parse state and optional result for one received byte.
// ----------------------------------------------------------------------------
module slcd_step (
	input  slcd_pkg::parse_state_t       st,
	input  slcd_pkg::cfg_t               cfg,
	input  logic [slcd_pkg::BYTE_W-1:0]  rx_byte,
	output slcd_pkg::parse_state_t       nxt,
	output logic                         emit,
	output slcd_pkg::result_t            res
);

	slcd_pkg::len_t              len_new;
	logic [slcd_pkg::INDEX_W-1:0] pay_len;
	logic [slcd_pkg::INDEX_W-1:0] count_inc;
	logic [slcd_pkg::BYTE_W-1:0]  sum_add;
	logic                         hunt;
	logic                         last;

	assign len_new   = slcd_pkg::LENGTH_BITS'({st.frame_len[7:0], rx_byte});
	assign pay_len   = slcd_pkg::INDEX_W'(st.frame_len - slcd_pkg::EMPTY_FRAME_LEN);
	assign count_inc = st.count + 1'b1;
	assign sum_add   = st.sum + rx_byte;
	assign last      = (count_inc == pay_len);

	always_comb begin
		nxt  = st;
		emit = 1'b0;
		hunt = 1'b0;
		res.kind           = slcd_pkg::KIND_PAYLOAD;
		res.payload_byte   = '0;
		res.byte_index     = '0;
		res.last_payload   = 1'b0;
		res.remark_id      = st.remark;
		res.frame_type     = st.ftype;
		res.payload_length = pay_len;

		unique case (st.phase)
			slcd_pkg::PH_SYNC1: begin
				hunt = 1'b1;
			end
			slcd_pkg::PH_SYNC2: begin
				if (rx_byte == cfg.sync_second) begin
					nxt.phase = slcd_pkg::PH_REMARK;
					nxt.sum   = sum_add;
				end else begin
					hunt = 1'b1;
				end
			end
			slcd_pkg::PH_REMARK: begin
				nxt.sum    = sum_add;
				nxt.remark = rx_byte;
				nxt.phase  = slcd_pkg::PH_LEN_HI;
			end
			slcd_pkg::PH_LEN_HI: begin
				nxt.sum       = sum_add;
				nxt.frame_len = (rx_byte == slcd_pkg::LEN_HI_AS_ZERO) ? '0 :
					slcd_pkg::LENGTH_BITS'(rx_byte);
				nxt.phase     = slcd_pkg::PH_LEN_LO;
			end
			slcd_pkg::PH_LEN_LO: begin
				if (len_new > slcd_pkg::LENGTH_BITS'(cfg.max_len) ||
					len_new > slcd_pkg::PAYLOAD_LIMIT_LEN) begin
					hunt = 1'b1;
				end else begin
					nxt.sum       = sum_add;
					nxt.frame_len = len_new;
					nxt.phase     = slcd_pkg::PH_TYPE;
				end
			end
			slcd_pkg::PH_TYPE: begin
				nxt.sum   = sum_add;
				nxt.ftype = rx_byte;
				nxt.phase = slcd_pkg::PH_PAYLOAD;
			end
			slcd_pkg::PH_PAYLOAD: begin
				// empty payload shows only once the first payload byte arrives
				if (st.count == '0 && st.frame_len <= slcd_pkg::EMPTY_FRAME_LEN) begin
					hunt = 1'b1;
				end else begin
					emit             = 1'b1;
					res.payload_byte = rx_byte;
					res.byte_index   = st.count;
					res.last_payload = last;
					nxt.sum   = sum_add;
					nxt.count = count_inc;
					if (last) begin
						nxt.phase = slcd_pkg::PH_CHECKSUM;
					end
				end
			end
			slcd_pkg::PH_CHECKSUM: begin
				emit = 1'b1;
				if (st.sum == rx_byte) begin
					res.kind      = slcd_pkg::KIND_SUM_OK;
					nxt.phase     = slcd_pkg::PH_SYNC1;
					nxt.frame_len = '0;
					nxt.sum       = '0;
					nxt.count     = '0;
				end else begin
					res.kind = slcd_pkg::KIND_SUM_BAD;
					hunt     = 1'b1;
				end
			end
			default: begin
				hunt = 1'b1;
			end
		endcase

		// frame dropped: the same byte may open a new frame
		if (hunt) begin
			nxt.frame_len = '0;
			nxt.count     = '0;
			if (rx_byte == cfg.sync_first) begin
				nxt.phase = slcd_pkg::PH_SYNC2;
				nxt.sum   = rx_byte;
			end else begin
				nxt.phase = slcd_pkg::PH_SYNC1;
				nxt.sum   = '0;
			end
		end
	end

endmodule

// ===== rtl/core/sync_length_checksum_deframer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_core
// Byte-stream frame receiver: sync pair, remark, length, type, payload, sum.
// ----------------------------------------------------------------------------
// Accepts one received byte per clock cycle, sustained, as long as results are
// taken. Each byte is captured in an input register and then parsed by a
// single state step that loads the output register. While a finished result
// waits on the output, one more byte is taken into the input register and
// then the input stalls until the result is taken. Payload bytes come out one
// item each, followed by a frame status item for the checksum byte; frames
// dropped before their payload give no item. Register writes take effect on
// the next byte parsed and belong to idle periods.
module sync_length_checksum_deframer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [slcd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [slcd_pkg::CFG_DATA_W-1:0]     cfg_data,
	slcd_in_if.sink                             in_ch,
	slcd_out_if.source                          out_ch
);

	slcd_pkg::cfg_t         cfg_q;
	slcd_pkg::parse_state_t st_q;
	slcd_pkg::parse_state_t st_nxt;
	slcd_pkg::result_t      res_nxt;
	slcd_pkg::result_t      out_res_q;
	logic                   emit;
	logic                   out_valid_q;
	logic                   in_valid_s1;
	logic [slcd_pkg::BYTE_W-1:0] in_byte_s1;
	logic                   advance;

	// parse stage moves when the output register is free or draining
	assign advance      = !out_valid_q || out_ch.ready;
	assign in_ch.ready  = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first  <= slcd_pkg::SYNC_FIRST_RST;
			cfg_q.sync_second <= slcd_pkg::SYNC_SECOND_RST;
			cfg_q.max_len     <= slcd_pkg::MAX_FRAME_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				slcd_pkg::CFG_SYNC_FIRST:  cfg_q.sync_first  <= cfg_data[slcd_pkg::BYTE_W-1:0];
				slcd_pkg::CFG_SYNC_SECOND: cfg_q.sync_second <= cfg_data[slcd_pkg::BYTE_W-1:0];
				slcd_pkg::CFG_MAX_LEN:     cfg_q.max_len     <= cfg_data[slcd_pkg::MAXLEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			in_valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			in_byte_s1 <= in_ch.rx_byte;
		end
	end

	slcd_step u_step (
		.st      (st_q),
		.cfg     (cfg_q),
		.rx_byte (in_byte_s1),
		.nxt     (st_nxt),
		.emit    (emit),
		.res     (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase     <= slcd_pkg::PH_SYNC1;
			st_q.frame_len <= '0;
			st_q.sum       <= '0;
			st_q.remark    <= '0;
			st_q.ftype     <= '0;
			st_q.count     <= '0;
		end else if (in_valid_s1 && advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= in_valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid_s1 && emit) begin
			out_res_q <= res_nxt;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.out_kind       = out_res_q.kind;
	assign out_ch.payload_byte   = out_res_q.payload_byte;
	assign out_ch.byte_index     = out_res_q.byte_index;
	assign out_ch.last_payload   = out_res_q.last_payload;
	assign out_ch.remark_id      = out_res_q.remark_id;
	assign out_ch.frame_type     = out_res_q.frame_type;
	assign out_ch.payload_length = out_res_q.payload_length;

endmodule
